### sv/rrw_pkg.sv
`timescale 1ns / 1ps

package rrw_pkg;

  // field widths of the channel words
  localparam int unsigned OP_W    = 1;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned PTYPE_W = 2;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned QUEUE_SIZE_DEF = 32;
  localparam int unsigned MAX_PAYLOAD    = 1400;

  typedef enum logic [OP_W-1:0] {
    OP_RECEIVE = 1'b0,
    OP_PROCESS = 1'b1
  } rrw_op_e;

  typedef enum logic [PTYPE_W-1:0] {
    PT_FULL   = 2'd0,
    PT_FIRST  = 2'd1,
    PT_MIDDLE = 2'd2,
    PT_LAST   = 2'd3
  } rrw_ptype_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_END     = 2'd2
  } rrw_kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED        = 3'd0,
    ST_OBSOLETE      = 3'd1,
    ST_OUT_OF_WINDOW = 3'd2,
    ST_DUPLICATE     = 3'd3,
    ST_CONFLICT      = 3'd4,
    ST_MALFORMED     = 3'd5
  } rrw_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RECV,
    S_HEAD_RD,
    S_HEAD,
    S_SCAN_RD,
    S_SCAN,
    S_EMIT_RD,
    S_EMIT,
    S_DONE
  } rrw_state_e;

  typedef struct packed {
    logic [ID_W-1:0]    seq;
    logic [PTYPE_W-1:0] kind;
    logic [SIZE_W-1:0]  bytes;
  } rrw_entry_t;

  typedef struct packed {
    rrw_kind_e          kind;
    rrw_status_e        status;
    logic [SLOT_W-1:0]  slot;
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic               msg_start;
    logic               msg_end;
    logic [COUNT_W-1:0] count;
    logic               last;
  } rrw_result_t;

endpackage

### sv/rrw_if.sv
`timescale 1ns / 1ps

// request channel: receive descriptor or process command
interface rrw_in_if import rrw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [ID_W-1:0]    packet_id;
  logic [PTYPE_W-1:0] packet_type;
  logic [SIZE_W-1:0]  payload_size;

  modport source (
    output valid, opcode, packet_id, packet_type, payload_size,
    input  ready
  );
  modport sink (
    input  valid, opcode, packet_id, packet_type, payload_size,
    output ready
  );
endinterface

// result channel: status, released descriptor or end marker
interface rrw_out_if import rrw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot_index;
  logic [ID_W-1:0]    released_id;
  logic [SIZE_W-1:0]  released_size;
  logic               message_start;
  logic               message_end;
  logic [COUNT_W-1:0] released_count;
  logic               last_result;

  modport source (
    output valid, result_kind, status, slot_index, released_id, released_size,
           message_start, message_end, released_count, last_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, status, slot_index, released_id, released_size,
           message_start, message_end, released_count, last_result,
    output ready
  );
endinterface

### sv/reorder_reassembly_window.sv
`timescale 1ns / 1ps

// Receive-side reorder window with fragment reassembly. A receive word is
// checked (malformed, obsolete, out of window, occupied slot) and stored in
// slot id mod QUEUE_SIZE; it answers with one status word (accept plus slot
// read, then check and write). A process word walks the window from the
// next expected id, releasing whole messages and complete fragment runs in
// order, one descriptor word per packet, then an end marker with the count.
// Each head check reads the slot, then decides, for a whole message or the
// first fragment of a run; each slot looked at during a fragment run scan
// and each released packet is likewise read, then handled (a whole message
// is checked and then reread). The walk ends with a head check where it
// stops (only the slot read when a full window was released) and the end
// marker. Every step is paced by the single slot memory read port with its
// registered read. Slot occupancy lives in per-slot flops that reset clears
// at once, so there is no clearing pass. Results sit in an output register;
// the next word is accepted while a result still waits.
module reorder_reassembly_window import rrw_pkg::*; #(
  parameter int unsigned QUEUE_SIZE = QUEUE_SIZE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rrw_in_if.sink    in_i,
  rrw_out_if.source out_o
);

  localparam int unsigned SlotW = (QUEUE_SIZE > 1) ? $clog2(QUEUE_SIZE) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_SIZE + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(QUEUE_SIZE - 1);
  localparam logic [SlotW:0]   QSum     = (SlotW + 1)'(QUEUE_SIZE);
  localparam logic [CntW-1:0]  QCnt     = CntW'(QUEUE_SIZE);
  localparam logic [CntW:0]    QLim     = (CntW + 1)'(QUEUE_SIZE);
  localparam logic [ID_W-1:0]  QId      = ID_W'(QUEUE_SIZE);
  localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(MAX_PAYLOAD);

  // slot of id + 1 given slot s of id; id space wraps back to slot zero
  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s,
                                                input logic [ID_W-1:0]  id);
    slot_inc = (s == LastSlot || id == '1) ? '0 : s + 1'b1;
  endfunction

  // state
  rrw_state_e state_q, state_d;
  logic [ID_W-1:0]       ldid_q, ldid_d;      // last delivered id
  logic [SlotW-1:0]      head_q, head_d;      // slot of last delivered id + 1
  logic [QUEUE_SIZE-1:0] valid_q;             // slot occupied
  logic [CntW-1:0]       cnt_q, cnt_d;        // descriptors released this walk
  logic [CntW-1:0]       j_q, j_d;            // scan offset within a run
  logic [CntW-1:0]       len_q, len_d;        // run length minus one
  logic [CntW-1:0]       k_q, k_d;            // emitted offset within a run
  logic [SlotW-1:0]      scan_slot_q, scan_slot_d;
  logic [ID_W-1:0]       scan_id_q, scan_id_d;

  // latched receive word
  logic [SlotW-1:0]   rcv_slot_q, rcv_slot_d;
  logic [ID_W-1:0]    rcv_id_q, rcv_id_d;
  logic [PTYPE_W-1:0] rcv_type_q, rcv_type_d;
  logic [SIZE_W-1:0]  rcv_size_q, rcv_size_d;
  rrw_status_e        rcv_pre_q, rcv_pre_d;

  // slot memory
  rrw_entry_t       mem [QUEUE_SIZE];
  rrw_entry_t       rd_q;
  logic [SlotW-1:0] rd_addr;
  logic             mem_we;
  logic             clr_valid;

  // output register
  rrw_result_t out_q;
  logic        out_valid_q;
  logic        out_free;
  logic        emit;
  rrw_result_t emit_res;

  logic             in_acc;
  logic [ID_W-1:0]  exp_id;
  logic [ID_W-1:0]  id_gap;
  logic [ID_W-1:0]  id_gap_m1;
  logic [SlotW:0]   slot_sum;
  logic [SlotW-1:0] rcv_slot_c;
  rrw_status_e      pre_c;
  rrw_status_e      recv_status;
  logic             head_hold;
  logic             scan_hold;
  logic [CntW:0]    scan_pos;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign exp_id     = ldid_q + 1'b1;

  // receive pre-checks, done on the incoming word
  assign id_gap    = in_i.packet_id - ldid_q;
  assign id_gap_m1 = id_gap - 1'b1;
  // in-window offset is below QUEUE_SIZE, so one conditional subtract wraps it
  assign slot_sum  = {1'b0, head_q} + {1'b0, id_gap_m1[SlotW-1:0]};

  always_comb begin
    if (in_i.packet_id < exp_id) begin
      // id wrapped past zero inside the window, so it is below QUEUE_SIZE
      rcv_slot_c = in_i.packet_id[SlotW-1:0];
    end else if (slot_sum >= QSum) begin
      rcv_slot_c = SlotW'(slot_sum - QSum);
    end else begin
      rcv_slot_c = slot_sum[SlotW-1:0];
    end
  end

  always_comb begin
    if (in_i.payload_size == '0 || in_i.payload_size > MaxSize) begin
      pre_c = ST_MALFORMED;
    end else if (id_gap == '0 || id_gap[ID_W-1]) begin
      pre_c = ST_OBSOLETE;
    end else if (id_gap > QId) begin
      pre_c = ST_OUT_OF_WINDOW;
    end else begin
      pre_c = ST_STORED;
    end
  end

  // occupied slot check once the entry has been read
  always_comb begin
    if (rcv_pre_q != ST_STORED) begin
      recv_status = rcv_pre_q;
    end else if (valid_q[rcv_slot_q]) begin
      if (rd_q.seq == rcv_id_q && rd_q.bytes == rcv_size_q) begin
        recv_status = ST_DUPLICATE;
      end else begin
        recv_status = ST_CONFLICT;
      end
    end else begin
      recv_status = ST_STORED;
    end
  end

  assign head_hold = valid_q[head_q] && (rd_q.seq == exp_id);
  assign scan_hold = valid_q[scan_slot_q] && (rd_q.seq == scan_id_q);
  assign scan_pos  = {1'b0, cnt_q} + {1'b0, j_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (rrw_op_e'(in_i.opcode) == OP_PROCESS) ? S_HEAD_RD : S_RECV;
        end
      end
      S_RECV: begin
        if (out_free) state_d = S_IDLE;
      end
      S_HEAD_RD: begin
        state_d = (cnt_q == QCnt) ? S_DONE : S_HEAD;
      end
      S_HEAD: begin
        if (!head_hold) begin
          state_d = S_DONE;
        end else begin
          case (rrw_ptype_e'(rd_q.kind))
            PT_FULL:  state_d = S_EMIT_RD;
            PT_FIRST: state_d = S_SCAN_RD;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = (scan_pos >= QLim) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (!scan_hold) begin
          state_d = S_DONE;
        end else begin
          case (rrw_ptype_e'(rd_q.kind))
            PT_LAST:   state_d = S_EMIT_RD;
            PT_MIDDLE: state_d = S_SCAN_RD;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_EMIT_RD: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_d = (k_q == len_q) ? S_HEAD_RD : S_EMIT_RD;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ldid_d      = ldid_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    len_d       = len_q;
    k_d         = k_q;
    scan_slot_d = scan_slot_q;
    scan_id_d   = scan_id_q;
    rcv_slot_d  = rcv_slot_q;
    rcv_id_d    = rcv_id_q;
    rcv_type_d  = rcv_type_q;
    rcv_size_d  = rcv_size_q;
    rcv_pre_d   = rcv_pre_q;
    rd_addr     = head_q;
    mem_we      = 1'b0;
    clr_valid   = 1'b0;
    emit        = 1'b0;
    emit_res    = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = rcv_slot_c;
        if (in_acc) begin
          rcv_slot_d = rcv_slot_c;
          rcv_id_d   = in_i.packet_id;
          rcv_type_d = in_i.packet_type;
          rcv_size_d = in_i.payload_size;
          rcv_pre_d  = pre_c;
          cnt_d      = '0;
        end
      end
      S_RECV: begin
        rd_addr         = rcv_slot_q;
        emit            = out_free;
        emit_res.kind   = KIND_STATUS;
        emit_res.status = recv_status;
        emit_res.last   = 1'b1;
        mem_we          = out_free && (recv_status == ST_STORED);
      end
      S_HEAD: begin
        if (head_hold) begin
          if (rrw_ptype_e'(rd_q.kind) == PT_FULL) begin
            len_d = '0;
            k_d   = '0;
          end else begin
            j_d         = CntW'(1);
            scan_slot_d = slot_inc(head_q, exp_id);
            scan_id_d   = exp_id + 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        rd_addr = scan_slot_q;
      end
      S_SCAN: begin
        rd_addr = scan_slot_q;
        if (scan_hold) begin
          if (rrw_ptype_e'(rd_q.kind) == PT_LAST) begin
            len_d = j_q;
            k_d   = '0;
          end else begin
            j_d         = j_q + 1'b1;
            scan_slot_d = slot_inc(scan_slot_q, scan_id_q);
            scan_id_d   = scan_id_q + 1'b1;
          end
        end
      end
      S_EMIT: begin
        emit               = out_free;
        emit_res.kind      = KIND_RELEASE;
        emit_res.slot      = SLOT_W'(head_q);
        emit_res.id        = exp_id;
        emit_res.size      = rd_q.bytes;
        emit_res.msg_start = (k_q == '0);
        emit_res.msg_end   = (k_q == len_q);
        if (out_free) begin
          clr_valid = 1'b1;
          ldid_d    = exp_id;
          head_d    = slot_inc(head_q, exp_id);
          cnt_d     = cnt_q + 1'b1;
          k_d       = k_q + 1'b1;
        end
      end
      S_DONE: begin
        emit           = out_free;
        emit_res.kind  = KIND_END;
        emit_res.count = COUNT_W'(cnt_q);
        emit_res.last  = 1'b1;
      end
      default: begin
        rd_addr = head_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ldid_q      <= '1;
      head_q      <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ldid_q  <= ldid_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      if (mem_we) valid_q[rcv_slot_q] <= 1'b1;
      if (clr_valid) valid_q[head_q] <= 1'b0;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    len_q       <= len_d;
    k_q         <= k_d;
    scan_slot_q <= scan_slot_d;
    scan_id_q   <= scan_id_d;
    rcv_slot_q  <= rcv_slot_d;
    rcv_id_q    <= rcv_id_d;
    rcv_type_q  <= rcv_type_d;
    rcv_size_q  <= rcv_size_d;
    rcv_pre_q   <= rcv_pre_d;
    if (emit) out_q <= emit_res;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[rcv_slot_q] <= '{seq: rcv_id_q, kind: rcv_type_q, bytes: rcv_size_q};
    end
    rd_q <= mem[rd_addr];
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_kind    = out_q.kind;
  assign out_o.status         = out_q.status;
  assign out_o.slot_index     = out_q.slot;
  assign out_o.released_id    = out_q.id;
  assign out_o.released_size  = out_q.size;
  assign out_o.message_start  = out_q.msg_start;
  assign out_o.message_end    = out_q.msg_end;
  assign out_o.released_count = out_q.count;
  assign out_o.last_result    = out_q.last;

`ifndef SYNTH
  // a walk never releases more than one window
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCnt)
    else $error("release count beyond window size");

  // head slot pointer stays inside the window
  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LastSlot)
    else $error("head slot out of range");

  // a released descriptor always comes from an occupied slot
  a_emit_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> valid_q[head_q])
    else $error("release from empty slot");

  // a stored descriptor marks its slot occupied
  a_store_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RECV && mem_we) |=> valid_q[$past(rcv_slot_q)])
    else $error("stored slot not marked occupied");
`endif

endmodule
